@@ sv/rau_pkg.sv @@
// ---------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ---------------------------------------------------------------------------
package rau_pkg;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

@@ sv/rau_if.sv @@
// ---------------------------------------------------------------------------
// rau_req_if / rau_res_if
// request and result channels of the rational arithmetic unit
// ---------------------------------------------------------------------------
interface rau_req_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [2:0]   op;
    logic [W-1:0] a_num;
    logic [W-1:0] a_den;
    logic [W-1:0] b_num;
    logic [W-2:0] b_den;
    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] res_num;
    logic [W-2:0] res_den;
    logic [1:0]   status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

@@ sv/rau_div.sv @@
// ---------------------------------------------------------------------------
// rau_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
#(
    parameter int NW = 128,
    parameter int DW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic [DW:0]   sh;
    logic [DW:0]   df;

    assign sh = {r_reg, q_reg[NW-1]};
    assign df = sh - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!df[DW])
            begin
                r_reg <= df[DW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= sh[DW-1:0];
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = q_reg;
    assign rem = r_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg) else $error("divider restarted while busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(run_reg)) else $error("done without run");
endmodule

@@ sv/rational_arithmetic_unit_core.sv @@
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_core
// fraction add/sub/mul/div/reduce with gcd reduction on one shared divider
// latency is data dependent: it grows with every division on the divider and every gcd step
// one item in flight at a time
// throughput is set by the single shared divider and the sequencer around it
// reset clears the sequencer and output valid; no memories, no clearing pass
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    rau_req_if.sink   req,
    rau_res_if.source res
);
    localparam int W  = DATA_WIDTH;
    localparam int NW = 2 * W;

    // states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_GA    = 5'd1;   // ad divided by gcd(am,ad)
    localparam logic [4:0] S_RA1   = 5'd2;
    localparam logic [4:0] S_RA2   = 5'd3;
    localparam logic [4:0] S_GB    = 5'd4;
    localparam logic [4:0] S_RB1   = 5'd5;
    localparam logic [4:0] S_RB2   = 5'd6;
    localparam logic [4:0] S_G1    = 5'd7;   // bd divided by gcd(bm,bd); starts the next gcd
    localparam logic [4:0] S_G2    = 5'd8;
    localparam logic [4:0] S_Q1    = 5'd9;
    localparam logic [4:0] S_Q2    = 5'd10;
    localparam logic [4:0] S_Q3    = 5'd11;
    localparam logic [4:0] S_Q4    = 5'd12;
    localparam logic [4:0] S_MUL1  = 5'd13;
    localparam logic [4:0] S_MUL2  = 5'd14;
    localparam logic [4:0] S_ASUM  = 5'd15;
    localparam logic [4:0] S_AREM  = 5'd16;
    localparam logic [4:0] S_AG2   = 5'd17;
    localparam logic [4:0] S_AQ    = 5'd18;
    localparam logic [4:0] S_AD    = 5'd19;
    localparam logic [4:0] S_EMIT  = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;
    localparam logic [4:0] S_GCD   = 5'd22;
    localparam logic [4:0] S_WAIT  = 5'd23;
    localparam logic [4:0] S_ERR   = 5'd24;

    logic [4:0]    st_reg, ret_reg;
    logic [2:0]    op_reg;
    logic          an_reg, bn_reg, neg_reg;
    logic [W-1:0]  am_reg, ad_reg, bm_reg, bd_reg;
    logic [W-1:0]  g_reg, g1_reg, g2_reg, t0_reg, t1_reg;
    logic [W-1:0]  gx_reg, gy_reg;
    logic [NW-1:0] x_reg, y_reg, num_reg, den_reg;
    logic [NW:0]   sum_reg;
    logic [1:0]    err_reg;
    logic          ov_reg;
    logic [W-1:0]  rn_reg;
    logic [W-2:0]  rd_reg;
    logic [1:0]    rs_reg;

    logic          dv_start;
    logic [NW-1:0] dv_num;
    logic [W-1:0]  dv_den;
    logic          dv_done;
    logic [NW-1:0] dv_quo;
    logic [W-1:0]  dv_rem;
    div_ctl_t      dctl;

    rau_div #(.NW(NW), .DW(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo),
        .rem   (dv_rem)
    );

    logic [NW-1:0] dn_reg;
    logic [W-1:0]  dd_reg;
    logic          go_reg;
    assign dv_start = go_reg;
    assign dv_num   = dn_reg;
    assign dv_den   = dd_reg;
    assign dctl.start = go_reg;
    assign dctl.busy  = (st_reg == S_WAIT) || (st_reg == S_GCD);

    // shared multiplier, registered before use
    logic [W-1:0]  ma, mb;
    logic [NW-1:0] mp;
    assign mp = NW'(ma) * NW'(mb);

    logic [W-1:0] mag_an, mag_ad, mag_bn;
    assign mag_an = req.a_num[W-1] ? (~req.a_num + 1'b1) : req.a_num;
    assign mag_ad = req.a_den[W-1] ? (~req.a_den + 1'b1) : req.a_den;
    assign mag_bn = req.b_num[W-1] ? (~req.b_num + 1'b1) : req.b_num;

    logic [W-1:0] half;
    assign half = {1'b1, {(W-1){1'b0}}};

    assign req.ready = (st_reg == S_IDLE) && !res.valid;
    assign res.res_num = rn_reg;
    assign res.res_den = rd_reg;
    assign res.status  = rs_reg;

    logic rv_reg;
    assign res.valid = rv_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            S_MUL1:  begin ma = t0_reg; mb = t1_reg; end
            S_MUL2:  begin ma = g1_reg; mb = g2_reg; end
            S_AREM:  begin ma = t0_reg; mb = t1_reg; end
            S_AG2:   begin ma = t0_reg; mb = t1_reg; end
            S_AD:    begin ma = t0_reg; mb = t1_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rv_reg <= 1'b0;
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (rv_reg && res.ready)
                rv_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        op_reg <= req.op;
                        am_reg <= mag_an;
                        ad_reg <= mag_ad;
                        bm_reg <= mag_bn;
                        bd_reg <= W'(req.b_den);
                        an_reg <= req.a_num[W-1] ^ req.a_den[W-1];
                        bn_reg <= req.b_num[W-1];
                        if (mag_ad == '0)
                        begin
                            err_reg <= ST_ZERO;
                            st_reg  <= S_ERR;
                        end
                        else
                        begin
                            gx_reg  <= mag_an;
                            gy_reg  <= mag_ad;
                            ret_reg <= S_RA1;
                            st_reg  <= S_GCD;
                        end
                    end
                end
                // euclid: gx = gcd(gx, gy) returned in g_reg
                S_GCD:
                begin
                    if (gy_reg == '0)
                    begin
                        g_reg  <= gx_reg;
                        st_reg <= ret_reg;
                    end
                    else
                    begin
                        dn_reg <= NW'(gx_reg);
                        dd_reg <= gy_reg;
                        go_reg <= 1'b1;
                        st_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (dv_done)
                    begin
                        gx_reg <= gy_reg;
                        gy_reg <= dv_rem;
                        st_reg <= S_GCD;
                    end
                end
                S_RA1:
                begin
                    dn_reg <= NW'(am_reg); dd_reg <= g_reg; go_reg <= 1'b1;
                    g1_reg <= g_reg;
                    st_reg <= S_RA2;
                end
                S_RA2:
                begin
                    if (dv_done)
                    begin
                        am_reg <= dv_quo[W-1:0];
                        dn_reg <= NW'(ad_reg); dd_reg <= g1_reg; go_reg <= 1'b1;
                        st_reg <= S_GA;
                    end
                end
                S_GA:
                begin
                    if (dv_done)
                    begin
                        if (am_reg == '0)
                        begin
                            ad_reg <= W'(1);
                            an_reg <= 1'b0;
                        end
                        else
                            ad_reg <= dv_quo[W-1:0];
                        if (op_reg[2])
                            st_reg <= S_RB1;
                        else if (bd_reg == '0)
                        begin
                            err_reg <= ST_ZERO;
                            st_reg  <= S_ERR;
                        end
                        else
                        begin
                            gx_reg  <= bm_reg;
                            gy_reg  <= bd_reg;
                            ret_reg <= S_GB;
                            st_reg  <= S_GCD;
                        end
                    end
                end
                S_RB1:
                begin
                    // reduce op: emit a directly
                    num_reg <= NW'(am_reg);
                    den_reg <= NW'(ad_reg);
                    neg_reg <= an_reg;
                    st_reg  <= S_EMIT;
                end
                S_GB:
                begin
                    dn_reg <= NW'(bm_reg); dd_reg <= g_reg; go_reg <= 1'b1;
                    g1_reg <= g_reg;
                    st_reg <= S_RB2;
                end
                S_RB2:
                begin
                    if (dv_done)
                    begin
                        bm_reg <= dv_quo[W-1:0];
                        dn_reg <= NW'(bd_reg); dd_reg <= g1_reg; go_reg <= 1'b1;
                        st_reg <= S_G1;
                    end
                end
                S_G1:
                begin
                    if (dv_done)
                    begin
                        if (bm_reg == '0)
                        begin
                            bd_reg <= W'(1);
                            bn_reg <= 1'b0;
                        end
                        else
                            bd_reg <= dv_quo[W-1:0];
                        if (op_reg == OP_DIV && bm_reg == '0)
                        begin
                            err_reg <= ST_ZERO;
                            st_reg  <= S_ERR;
                        end
                        else if (op_reg == OP_MUL)
                        begin
                            gx_reg <= am_reg;
                            gy_reg <= (bm_reg == '0) ? W'(1) : dv_quo[W-1:0];
                            ret_reg <= S_G2;
                            st_reg  <= S_GCD;
                        end
                        else if (op_reg == OP_DIV)
                        begin
                            gx_reg  <= am_reg;
                            gy_reg  <= bm_reg;
                            ret_reg <= S_G2;
                            st_reg  <= S_GCD;
                        end
                        else
                        begin
                            gx_reg  <= ad_reg;
                            gy_reg  <= (bm_reg == '0) ? W'(1) : dv_quo[W-1:0];
                            ret_reg <= S_Q1;
                            st_reg  <= S_GCD;
                        end
                    end
                end
                // mul: g1=gcd(am,bd) then g2=gcd(bm,ad)
                // div: g1=gcd(am,bm) then g2=gcd(ad,bd)
                S_G2:
                begin
                    t0_reg <= g_reg;
                    if (op_reg == OP_MUL)
                    begin
                        gx_reg <= bm_reg;
                        gy_reg <= ad_reg;
                    end
                    else
                    begin
                        gx_reg <= ad_reg;
                        gy_reg <= bd_reg;
                    end
                    ret_reg <= S_Q2;
                    st_reg  <= S_GCD;
                end
                S_Q2:
                begin
                    t1_reg <= g_reg;
                    dn_reg <= NW'(am_reg); dd_reg <= t0_reg; go_reg <= 1'b1;
                    st_reg <= S_Q3;
                end
                S_Q3:
                begin
                    if (dv_done)
                    begin
                        am_reg <= dv_quo[W-1:0];
                        // second: mul bm/g2, div bd/g2
                        dn_reg <= NW'((op_reg == OP_MUL) ? bm_reg : bd_reg);
                        dd_reg <= t1_reg; go_reg <= 1'b1;
                        st_reg <= S_Q4;
                    end
                end
                S_Q4:
                begin
                    if (dv_done)
                    begin
                        if (op_reg == OP_MUL) bm_reg <= dv_quo[W-1:0];
                        else bd_reg <= dv_quo[W-1:0];
                        dn_reg <= NW'(ad_reg); dd_reg <= t1_reg; go_reg <= 1'b1;
                        st_reg <= S_ASUM;
                        ret_reg <= S_IDLE;
                    end
                end
                S_ASUM:
                begin
                    if (dv_done)
                    begin
                        if (ret_reg == S_IDLE)
                        begin
                            ad_reg <= dv_quo[W-1:0];
                            // third: mul bd/g1, div bm/g1
                            dn_reg <= NW'((op_reg == OP_MUL) ? bd_reg : bm_reg);
                            dd_reg <= t0_reg; go_reg <= 1'b1;
                            ret_reg <= S_OUT;
                        end
                        else
                        begin
                            g2_reg <= dv_quo[W-1:0];
                            t0_reg <= am_reg;
                            t1_reg <= (op_reg == OP_MUL) ? bm_reg : bd_reg;
                            g1_reg <= ad_reg;
                            neg_reg <= an_reg ^ bn_reg;
                            st_reg <= S_MUL1;
                        end
                    end
                end
                S_MUL1:
                begin
                    num_reg <= mp;
                    st_reg  <= S_MUL2;
                end
                S_MUL2:
                begin
                    den_reg <= mp;
                    st_reg  <= (op_reg <= OP_SUB) ? S_AD : S_EMIT;
                end
                // add/sub: g = gcd(ad,bd) in g_reg
                S_Q1:
                begin
                    g2_reg <= g_reg;
                    dn_reg <= NW'(bd_reg); dd_reg <= g_reg; go_reg <= 1'b1;
                    st_reg <= S_AREM;
                    ret_reg <= S_IDLE;
                end
                S_AREM:
                begin
                    if (dv_done)
                    begin
                        if (ret_reg == S_IDLE)
                        begin
                            t0_reg <= am_reg;
                            t1_reg <= dv_quo[W-1:0];
                            dn_reg <= NW'(ad_reg); dd_reg <= g2_reg; go_reg <= 1'b1;
                            ret_reg <= S_OUT;
                        end
                        else
                        begin
                            t0_reg <= bm_reg;
                            t1_reg <= dv_quo[W-1:0];
                            g1_reg <= dv_quo[W-1:0];
                            x_reg  <= mp;
                            st_reg <= S_AG2;
                        end
                    end
                    else if (ret_reg == S_OUT && !go_reg && !dctl.busy)
                        x_reg <= mp;
                end
                S_AG2:
                begin
                    // y = bm * adr, then combine
                    y_reg  <= mp;
                    st_reg <= S_AQ;
                end
                S_AQ:
                begin
                    if (an_reg == (bn_reg ^ (op_reg == OP_SUB)))
                    begin
                        sum_reg <= {1'b0, x_reg} + {1'b0, y_reg};
                        neg_reg <= an_reg;
                    end
                    else if (x_reg >= y_reg)
                    begin
                        sum_reg <= {1'b0, x_reg - y_reg};
                        neg_reg <= an_reg;
                    end
                    else
                    begin
                        sum_reg <= {1'b0, y_reg - x_reg};
                        neg_reg <= bn_reg ^ (op_reg == OP_SUB);
                    end
                    st_reg <= S_OUT;
                    ret_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (ret_reg == S_IDLE)
                    begin
                        // overflow of sum beyond 2W bits cannot be divided here
                        ov_reg <= sum_reg[NW];
                        dn_reg <= sum_reg[NW-1:0]; dd_reg <= g2_reg; go_reg <= 1'b1;
                        ret_reg <= S_WAIT;
                    end
                    else if (dv_done && ret_reg == S_WAIT)
                    begin
                        gx_reg  <= g2_reg;
                        gy_reg  <= dv_rem;
                        st_reg  <= S_GCD;
                        t1_reg  <= '0;
                        ret_reg <= S_EMIT;
                    end
                    else if (dv_done)
                    begin
                        t1_reg <= dv_quo[W-1:0];
                        st_reg <= S_ASUM;
                        ret_reg <= S_MUL1;
                    end
                end
                S_EMIT:
                begin
                    if (op_reg <= OP_SUB && ret_reg == S_EMIT)
                    begin
                        // divide sum by g = gcd(g2, rem)
                        dn_reg <= sum_reg[NW-1:0]; dd_reg <= g_reg; go_reg <= 1'b1;
                        ret_reg <= S_MUL2;
                        st_reg <= S_AD;
                    end
                    else if (!rv_reg)
                    begin
                        rv_reg <= 1'b1;
                        st_reg <= S_IDLE;
                        if (num_reg == '0)
                        begin
                            rn_reg <= '0;
                            rd_reg <= (W-1)'(1);
                            rs_reg <= ST_OK;
                        end
                        else if (ov_reg && op_reg <= OP_SUB ||
                                 num_reg[NW-1:W] != '0 || den_reg[NW-1:W-1] != '0 ||
                                 num_reg[W-1:0] > half ||
                                 (num_reg[W-1:0] == half && !neg_reg))
                        begin
                            rn_reg <= '0;
                            rd_reg <= '0;
                            rs_reg <= ST_OVF;
                        end
                        else
                        begin
                            rn_reg <= neg_reg ? (~num_reg[W-1:0] + 1'b1) : num_reg[W-1:0];
                            rd_reg <= den_reg[W-2:0];
                            rs_reg <= ST_OK;
                        end
                    end
                end
                S_AD:
                begin
                    if (ret_reg == S_MUL2)
                    begin
                        if (dv_done)
                        begin
                            num_reg <= dv_quo;
                            dn_reg <= NW'(bd_reg); dd_reg <= g_reg; go_reg <= 1'b1;
                            ret_reg <= S_IDLE;
                        end
                    end
                    else if (ret_reg == S_IDLE)
                    begin
                        if (dv_done)
                        begin
                            t0_reg <= g1_reg;
                            t1_reg <= dv_quo[W-1:0];
                            ret_reg <= S_RB1;
                        end
                    end
                    else if (ret_reg == S_RB1)
                    begin
                        den_reg <= mp;
                        ret_reg <= S_IDLE;
                        st_reg  <= S_EMIT;
                        ov_reg  <= ov_reg;
                    end
                    else
                        st_reg <= S_EMIT;
                end
                S_ERR:
                begin
                    if (!rv_reg)
                    begin
                        rn_reg <= '0;
                        rd_reg <= '0;
                        rs_reg <= err_reg;
                        rv_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !req.ready) else $error("ready while busy");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid) else $error("result dropped");
    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_OK) |-> (res.res_den != '0))
        else $error("ok result with zero denominator");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != ST_OK) |-> (res.res_num == '0))
        else $error("error result with nonzero numerator");
endmodule
